FILE: sv/terminated_line_framer_top_defines.svh
// ----------------------------------------------------------------------------
// Terminated line framer: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TERMINATED_LINE_FRAMER_TOP_DEFINES_SVH
`define TERMINATED_LINE_FRAMER_TOP_DEFINES_SVH

// expression holds at every edge
`define TLF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle
`define TLF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define TLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tlf_pkg.sv
// ----------------------------------------------------------------------------
// Terminated line framer package
// Constants, terminator decode and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int DEF_LINE_DEPTH = 64;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_BELL = 8'h07;
  localparam logic [7:0] CHAR_GT   = 8'h3E;

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_BELL) || (b == CHAR_GT);
  endfunction

  typedef struct packed {
    logic store;
    logic mark_ovf;
    logic start;
    logic fetch;
    logic advance;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic term;
    logic full;
    logic empty;
    logic last;
  } status_t;

endpackage

FILE: sv/tlf_ifs.sv
// ----------------------------------------------------------------------------
// Terminated line framer channels
// Valid/ready channels for received bytes and emitted line characters.
// ----------------------------------------------------------------------------
interface line_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface line_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_char;
  logic       line_last;
  logic       line_overflow;

  modport source (output valid, output line_char, output line_last, output line_overflow,
                  input ready);
  modport sink (input valid, input line_char, input line_last, input line_overflow,
                output ready);
endinterface

FILE: sv/tlf_datapath.sv
// ----------------------------------------------------------------------------
// Terminated line framer datapath
// Line store memory, length and overflow tracking, and the read pointer.
// ----------------------------------------------------------------------------
`include "terminated_line_framer_top_defines.svh"

module tlf_datapath #(
  parameter int LINE_DEPTH = tlf_pkg::DEF_LINE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tlf_pkg::cmd_t    cmd,
  output tlf_pkg::status_t status,
  input  logic [7:0]       rx_byte,
  output logic [7:0]       line_char,
  output logic             line_last,
  output logic             line_overflow
);
  import tlf_pkg::*;

  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int LEN_W  = $clog2(LINE_DEPTH + 1);

  logic [7:0]        mem_r [LINE_DEPTH];
  logic [7:0]        rdata_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] rd_r, rd_nxt;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem_r[len_r[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rdata_r <= mem_r[rd_r];
    end
  end

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    rd_nxt  = rd_r;
    if (cmd.store) begin
      len_nxt = len_r + LEN_W'(1);
    end
    if (cmd.mark_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.start || cmd.clear) begin
      rd_nxt = '0;
    end else if (cmd.advance) begin
      rd_nxt = rd_r + ADDR_W'(1);
    end
    if (cmd.clear) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      rd_r  <= '0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      rd_r  <= rd_nxt;
    end
  end

  assign status.term  = is_terminator(rx_byte);
  assign status.full  = (len_r == LEN_W'(LINE_DEPTH));
  assign status.empty = (len_r == '0);
  assign status.last  = ((LEN_W'(rd_r) + LEN_W'(1)) == len_r);

  assign line_char     = rdata_r;
  assign line_last     = status.last;
  assign line_overflow = ovf_r;

  `TLF_ASSERT_ALWAYS(a_len_bound, len_r <= LEN_W'(LINE_DEPTH), "line length beyond store depth")
  `TLF_ASSERT_IMPLY(a_store_room, cmd.store, !status.full, "append into a full line store")
  `TLF_ASSERT_NEXT(a_clear_empty, cmd.clear, len_r == '0 && !ovf_r, "line not cleared after emit")

endmodule

FILE: sv/tlf_ctrl.sv
// ----------------------------------------------------------------------------
// Terminated line framer controller
// Accepts bytes while idle and steps the datapath through line emission.
// ----------------------------------------------------------------------------
module tlf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tlf_pkg::status_t status,
  output tlf_pkg::cmd_t    cmd
);
  import tlf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!status.term) begin
            if (!status.full) begin
              cmd.store = 1'b1;
            end else begin
              cmd.mark_ovf = 1'b1;
            end
          end else if (!status.empty) begin
            cmd.start = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/terminated_line_framer_top.sv
// ----------------------------------------------------------------------------
// Terminated line framer
// Collects received bytes into a line and emits each finished line.
//
// in_if carries one received byte per request; out_if carries one line
// character per request with last and overflow flags. Newline, carriage
// return, bell and '>' end a line and are never stored or emitted; an empty
// line is dropped. Ordinary bytes are taken one per cycle while the block
// is idle. After a terminator that closes a line, the controller steps
// through each character in turn: a registered read of the line store in
// the read state, then the character is offered in the show state until
// the receiver takes it. No byte is taken during emission. A stalled
// receiver holds the current character and the whole block. Bytes beyond
// LINE_DEPTH are dropped and every character of that line is flagged.
// Synchronous reset empties the pending line and clears the overflow flag;
// store contents are not cleared.
// ----------------------------------------------------------------------------
module terminated_line_framer_top #(
  parameter int LINE_DEPTH = tlf_pkg::DEF_LINE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  line_in_if.sink    in_if,
  line_out_if.source out_if
);
  import tlf_pkg::*;

  cmd_t    cmd;
  status_t status;

  tlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tlf_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .rx_byte       (in_if.rx_byte),
    .line_char     (out_if.line_char),
    .line_last     (out_if.line_last),
    .line_overflow (out_if.line_overflow)
  );

endmodule
